FILE: rtl/pclb_pkg.sv
package pclb_pkg;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_MOVE   = 2'd2;
   localparam logic [1:0] ACT_QUERY  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OOB  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [2:0] REG_CELLS_X = 3'd0;
   localparam logic [2:0] REG_CELLS_Y = 3'd1;
   localparam logic [2:0] REG_CELLS_Z = 3'd2;
   localparam logic [2:0] REG_SCALE_X = 3'd3;
   localparam logic [2:0] REG_SCALE_Y = 3'd4;
   localparam logic [2:0] REG_SCALE_Z = 3'd5;

   localparam int DIV_NUM_W = 36;
   localparam int DIV_DEN_W = 13;
   localparam int DIV_DIGIT = 4;

   typedef struct packed {
      logic [1:0]         action;
      logic [13:0]        particle;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [11:0]        query_cell;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] new_cell;
      logic [11:0] old_cell;
      logic        moved;
      logic [11:0] neighbour_cell;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
      logic [DIV_DEN_W-1:0] remainder;
   } div_rsp_type;

endpackage

FILE: rtl/periodic_cell_list_binner_top.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_data (req_type)
// rsp       out        rsp_valid/rsp_ready  rsp_data (rsp_type)
// csr       in         psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// one transaction at a time; per axis a 32x32 multiply, a wide add and a pass through the
// shared remainder unit; binning stops early when an axis is out of box
// insert or refused move: one result; an accepted move scans the old cell, swaps its last
// entry into the hole and appends to the new one; neighbour list: 27 results, one a cycle
// while rsp is free; clear and reset sweep the count memory, no req taken meanwhile
// rsp is a single output register; a full register stalls only the next write
module periodic_cell_list_binner_top
   import pclb_pkg::*;
#(
   parameter int MAX_CELLS     = 4096,
   parameter int CELL_CAPACITY = 32,
   parameter int MAX_PARTICLES = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CA_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int PA_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int MA_W = $clog2(MAX_CELLS * CELL_CAPACITY);
   localparam int IX_W = $clog2(CELL_CAPACITY);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_BIN_MUL, S_BIN_ADD, S_BIN_DIV, S_BIN_ID, S_RD, S_CHECK,
      S_OLD_WAIT, S_LAST_RD, S_LAST_WAIT, S_SCAN, S_APPEND, S_EMIT,
      S_Q_MOD, S_Q_X, S_Q_YZ, S_NB
   } state_type;

   state_type state_ff;

   // configuration
   logic [4:0]  cells_x_ff, cells_y_ff, cells_z_ff;
   logic [31:0] scale_x_ff, scale_y_ff, scale_z_ff;
   logic [4:0]  ecx, ecy, ecz;

   function automatic logic [4:0] eff_cells(input logic [4:0] n);
      if (n == 5'd0) return 5'd1;
      if (n > 5'd16) return 5'd16;
      return n;
   endfunction

   function automatic logic [3:0] wrap(input logic [3:0] c, input logic [1:0] off,
                                       input logic [4:0] n);
      logic [4:0] up;
      up = {1'b0, c} + 5'd1;
      case (off)
         2'd0:    return (c == 4'd0) ? 4'(n - 5'd1) : c - 4'd1;
         2'd1:    return c;
         default: return (up == n) ? 4'd0 : up[3:0];
      endcase
   endfunction

   assign ecx = eff_cells(cells_x_ff);
   assign ecy = eff_cells(cells_y_ff);
   assign ecz = eff_cells(cells_z_ff);

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= 5'd1;
         cells_y_ff <= 5'd1;
         cells_z_ff <= 5'd1;
         scale_x_ff <= 32'd65536;
         scale_y_ff <= 32'd65536;
         scale_z_ff <= 32'd65536;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            REG_CELLS_X: cells_x_ff <= pwdata[4:0];
            REG_CELLS_Y: cells_y_ff <= pwdata[4:0];
            REG_CELLS_Z: cells_z_ff <= pwdata[4:0];
            REG_SCALE_X: scale_x_ff <= pwdata;
            REG_SCALE_Y: scale_y_ff <= pwdata;
            REG_SCALE_Z: scale_z_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_CELLS_X: prdata = {27'd0, cells_x_ff};
         REG_CELLS_Y: prdata = {27'd0, cells_y_ff};
         REG_CELLS_Z: prdata = {27'd0, cells_z_ff};
         REG_SCALE_X: prdata = scale_x_ff;
         REG_SCALE_Y: prdata = scale_y_ff;
         REG_SCALE_Z: prdata = scale_z_ff;
         default:     prdata = 32'd0;
      endcase
   end

   // datapath registers
   req_type              req_ff;
   rsp_type              res_ff;
   rsp_type              rsp_data_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [1:0]           axis_ff;
   logic                 neg_ff;
   logic [63:0]          prod_ff;
   logic [3:0]           coord_ff [3];
   logic [11:0]          id_ff;
   logic                 oob_ff;
   logic [11:0]          oc_ff;
   logic [IX_W-1:0]      cnt_new_ff;
   logic [IX_W-1:0]      n_ff;
   logic [IX_W-1:0]      j_ff;
   logic [13:0]          last_ff;
   logic [CA_W-1:0]      clr_addr_ff;
   logic                 clr_resp_ff;
   logic [3:0]           qx_ff, qy_ff, qz_ff;
   logic [1:0]           off_a_ff, off_b_ff, off_c_ff;
   logic                 div_start_ff;
   logic                 div_start_in;
   logic [DIV_NUM_W-1:0] div_a_ff;
   logic [DIV_DEN_W-1:0] div_b_ff;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = div_a_ff;
   assign div_req.divisor  = div_b_ff;

   pclb_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // per-axis binning
   logic [31:0] pos_sel, scale_sel, mag;
   logic [4:0]  n_sel;
   logic [65:0] sum_s;
   logic        ax_oob;
   logic [32:0] t_ax;
   logic [12:0] id_full, n_yz, n_all;

   always_comb begin
      case (axis_ff)
         2'd0:    begin pos_sel = req_ff.pos_x; scale_sel = scale_x_ff; n_sel = ecx; end
         2'd1:    begin pos_sel = req_ff.pos_y; scale_sel = scale_y_ff; n_sel = ecy; end
         default: begin pos_sel = req_ff.pos_z; scale_sel = scale_z_ff; n_sel = ecz; end
      endcase
   end

   assign mag   = pos_sel[31] ? (~pos_sel + 32'd1) : pos_sel;
   assign sum_s = neg_ff ? ({30'd0, n_sel, 31'd0} - {2'b00, prod_ff})
                         : ({30'd0, n_sel, 31'd0} + {2'b00, prod_ff});
   // negative sums strictly within one unit of zero truncate to zero
   assign ax_oob = sum_s[65] && !((&sum_s[65:32]) && (|sum_s[31:0]));
   assign t_ax   = sum_s[65] ? 33'd0 : sum_s[64:32];

   assign id_full = (13'(coord_ff[0]) * 13'(ecy) + 13'(coord_ff[1])) * 13'(ecz)
                    + 13'(coord_ff[2]);
   assign n_yz    = 13'(ecy) * 13'(ecz);
   assign n_all   = n_yz * 13'(ecx);

   // neighbour id
   logic [3:0]  nx, ny, nz;
   logic [12:0] nb_id;
   logic        nb_last;

   assign nx      = wrap(qx_ff, off_a_ff, ecx);
   assign ny      = wrap(qy_ff, off_b_ff, ecy);
   assign nz      = wrap(qz_ff, off_c_ff, ecz);
   assign nb_id   = (13'(nx) * 13'(ecy) + 13'(ny)) * 13'(ecz) + 13'(nz);
   assign nb_last = (off_a_ff == 2'd2) && (off_b_ff == 2'd2) && (off_c_ff == 2'd2);

   // memories
   logic [IX_W-1:0] cnt_mem  [MAX_CELLS];
   logic [13:0]     memb_mem [MAX_CELLS * CELL_CAPACITY];
   logic [11:0]     home_mem [MAX_PARTICLES];

   logic [IX_W-1:0] cnt_rd_ff, cnt_wdata;
   logic [CA_W-1:0] cnt_raddr, cnt_waddr;
   logic            cnt_we;
   logic [13:0]     memb_rd_ff, memb_wdata;
   logic [MA_W-1:0] memb_raddr, memb_waddr, base_id, base_oc;
   logic            memb_we;
   logic [11:0]     home_rd_ff, home_oc;
   logic [PA_W-1:0] home_addr;
   logic            home_we;

   logic full, ins_ok, scan_hit, out_free;

   assign full     = cnt_rd_ff >= IX_W'(CELL_CAPACITY - 1);
   assign home_oc  = (13'(home_rd_ff) >= 13'(MAX_CELLS)) ? 12'd0 : home_rd_ff;
   assign ins_ok   = (state_ff == S_CHECK) && (req_ff.action == ACT_INSERT)
                     && !oob_ff && !full;
   assign scan_hit = (state_ff == S_SCAN) && (memb_rd_ff == req_ff.particle);
   assign base_id  = MA_W'(id_ff) * MA_W'(CELL_CAPACITY);
   assign base_oc  = MA_W'(oc_ff) * MA_W'(CELL_CAPACITY);
   assign home_addr = PA_W'(req_ff.particle);
   assign home_we  = ins_ok || (state_ff == S_APPEND);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cnt_raddr = (state_ff == S_CHECK) ? CA_W'(home_oc) : CA_W'(id_ff);
      cnt_we    = 1'b0;
      cnt_waddr = CA_W'(id_ff);
      cnt_wdata = cnt_rd_ff + IX_W'(1);
      memb_we    = 1'b0;
      memb_waddr = base_id + MA_W'(cnt_rd_ff);
      memb_wdata = req_ff.particle;
      if (state_ff == S_CLEAR) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_addr_ff;
         cnt_wdata = '0;
      end else if (ins_ok) begin
         cnt_we  = 1'b1;
         memb_we = 1'b1;
      end else if (scan_hit) begin
         // swap the last entry into the hole
         cnt_we     = 1'b1;
         cnt_waddr  = CA_W'(oc_ff);
         cnt_wdata  = n_ff - IX_W'(1);
         memb_we    = 1'b1;
         memb_waddr = base_oc + MA_W'(j_ff);
         memb_wdata = last_ff;
      end else if (state_ff == S_APPEND) begin
         cnt_we     = 1'b1;
         cnt_wdata  = cnt_new_ff + IX_W'(1);
         memb_we    = 1'b1;
         memb_waddr = base_id + MA_W'(cnt_new_ff);
      end
      case (state_ff)
         S_LAST_RD:   memb_raddr = base_oc + MA_W'(n_ff - IX_W'(1));
         S_LAST_WAIT: memb_raddr = base_oc;
         default:     memb_raddr = base_oc + MA_W'(j_ff) + MA_W'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (memb_we) memb_mem[memb_waddr] <= memb_wdata;
      memb_rd_ff <= memb_mem[memb_raddr];
   end

   always_ff @(posedge clock) begin
      if (home_we) home_mem[home_addr] <= id_ff;
      home_rd_ff <= home_mem[home_addr];
   end

   assign div_start_in = ((state_ff == S_IDLE) && req_valid && (req_data.action == ACT_QUERY))
                         || ((state_ff == S_BIN_ADD) && !ax_oob)
                         || (((state_ff == S_Q_MOD) || (state_ff == S_Q_X)) && div_rsp.done);
   assign rsp_valid_in = (out_free && ((state_ff == S_EMIT) || (state_ff == S_NB)))
                         || (rsp_valid_ff && !rsp_ready);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_CLEAR: begin
               if (clr_addr_ff == CA_W'(MAX_CELLS - 1)) begin
                  if (clr_resp_ff) begin
                     res_ff      <= '{ST_OK, 12'd0, 12'd0, 1'b0, 12'd0, 1'b1};
                     clr_resp_ff <= 1'b0;
                     state_ff    <= S_EMIT;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  clr_addr_ff <= clr_addr_ff + CA_W'(1);
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff  <= req_data;
                  oob_ff  <= 1'b0;
                  axis_ff <= 2'd0;
                  case (req_data.action)
                     ACT_CLEAR: begin
                        clr_addr_ff <= '0;
                        clr_resp_ff <= 1'b1;
                        state_ff    <= S_CLEAR;
                     end
                     ACT_QUERY: begin
                        div_a_ff     <= DIV_NUM_W'(req_data.query_cell);
                        div_b_ff     <= n_all;
                        state_ff     <= S_Q_MOD;
                     end
                     default: begin
                        if (17'(req_data.particle) >= 17'(MAX_PARTICLES)) begin
                           res_ff   <= '{ST_OOB, 12'd0, 12'd0, 1'b0, 12'd0, 1'b1};
                           state_ff <= S_EMIT;
                        end else begin
                           state_ff <= S_BIN_MUL;
                        end
                     end
                  endcase
               end
            end
            S_BIN_MUL: begin
               neg_ff   <= pos_sel[31];
               prod_ff  <= mag * scale_sel;
               state_ff <= S_BIN_ADD;
            end
            S_BIN_ADD: begin
               if (ax_oob) begin
                  oob_ff   <= 1'b1;
                  state_ff <= S_RD;
               end else begin
                  div_a_ff     <= DIV_NUM_W'(t_ax);
                  div_b_ff     <= DIV_DEN_W'(n_sel);
                  state_ff     <= S_BIN_DIV;
               end
            end
            S_BIN_DIV: begin
               if (div_rsp.done) begin
                  coord_ff[axis_ff] <= div_rsp.remainder[3:0];
                  if (axis_ff == 2'd2) begin
                     state_ff <= S_BIN_ID;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= S_BIN_MUL;
                  end
               end
            end
            S_BIN_ID: begin
               id_ff <= id_full[11:0];
               if (id_full >= 13'(MAX_CELLS)) oob_ff <= 1'b1;
               state_ff <= S_RD;
            end
            S_RD: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               state_ff <= S_EMIT;
               if (req_ff.action == ACT_INSERT) begin
                  if (oob_ff)
                     res_ff <= '{ST_OOB, 12'd0, 12'd0, 1'b0, 12'd0, 1'b1};
                  else if (full)
                     res_ff <= '{ST_FULL, 12'd0, 12'd0, 1'b0, 12'd0, 1'b1};
                  else
                     res_ff <= '{ST_OK, id_ff, 12'd0, 1'b0, 12'd0, 1'b1};
               end else begin
                  oc_ff      <= home_oc;
                  cnt_new_ff <= cnt_rd_ff;
                  if (oob_ff)
                     res_ff <= '{ST_OOB, home_oc, home_oc, 1'b0, 12'd0, 1'b1};
                  else if (id_ff == home_oc)
                     res_ff <= '{ST_OK, home_oc, home_oc, 1'b0, 12'd0, 1'b1};
                  else if (full)
                     res_ff <= '{ST_FULL, home_oc, home_oc, 1'b0, 12'd0, 1'b1};
                  else
                     state_ff <= S_OLD_WAIT;
               end
            end
            S_OLD_WAIT: begin
               n_ff <= cnt_rd_ff;
               state_ff <= (cnt_rd_ff == '0) ? S_APPEND : S_LAST_RD;
            end
            S_LAST_RD: begin
               state_ff <= S_LAST_WAIT;
            end
            S_LAST_WAIT: begin
               last_ff  <= memb_rd_ff;
               j_ff     <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (scan_hit || (j_ff == n_ff - IX_W'(1))) begin
                  state_ff <= S_APPEND;
               end else begin
                  j_ff <= j_ff + IX_W'(1);
               end
            end
            S_APPEND: begin
               res_ff   <= '{ST_OK, id_ff, oc_ff, 1'b1, 12'd0, 1'b1};
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_data_ff  <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            S_Q_MOD: begin
               if (div_rsp.done) begin
                  div_a_ff     <= DIV_NUM_W'(div_rsp.remainder);
                  div_b_ff     <= n_yz;
                  state_ff     <= S_Q_X;
               end
            end
            S_Q_X: begin
               if (div_rsp.done) begin
                  qx_ff        <= div_rsp.quotient[3:0];
                  div_a_ff     <= DIV_NUM_W'(div_rsp.remainder);
                  div_b_ff     <= DIV_DEN_W'(ecz);
                  state_ff     <= S_Q_YZ;
               end
            end
            S_Q_YZ: begin
               if (div_rsp.done) begin
                  qy_ff    <= div_rsp.quotient[3:0];
                  qz_ff    <= div_rsp.remainder[3:0];
                  off_a_ff <= 2'd0;
                  off_b_ff <= 2'd0;
                  off_c_ff <= 2'd0;
                  state_ff <= S_NB;
               end
            end
            S_NB: begin
               if (out_free) begin
                  rsp_data_ff  <= '{ST_OK, 12'd0, 12'd0, 1'b0, nb_id[11:0], nb_last};
                  // z offset runs fastest
                  if (off_c_ff != 2'd2) begin
                     off_c_ff <= off_c_ff + 2'd1;
                  end else begin
                     off_c_ff <= 2'd0;
                     if (off_b_ff != 2'd2) begin
                        off_b_ff <= off_b_ff + 2'd1;
                     end else begin
                        off_b_ff <= 2'd0;
                        off_a_ff <= off_a_ff + 2'd1;
                     end
                  end
                  if (nb_last) state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/pclb_divider.sv
module pclb_divider
   import pclb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int STEPS = DIV_NUM_W / DIV_DIGIT;
   localparam int SW    = $clog2(STEPS);

   logic                 busy_ff;
   logic                 done_ff;
   logic [SW-1:0]        step_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] rem_in;
   logic [DIV_DIGIT-1:0] qbits_in;

   // four restoring steps per cycle, remainder stays below the divisor
   always_comb begin
      logic [DIV_DEN_W:0] r;
      r = {1'b0, rem_ff};
      qbits_in = '0;
      for (int i = 0; i < DIV_DIGIT; i++) begin
         r = {r[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1-i]};
         if (r >= {1'b0, den_ff}) begin
            r = r - {1'b0, den_ff};
            qbits_in[DIV_DIGIT-1-i] = 1'b1;
         end
      end
      rem_in = r[DIV_DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= !div_req.start && busy_ff && (step_ff == SW'(STEPS - 1));
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            quo_ff  <= div_req.dividend;
            rem_ff  <= '0;
            den_ff  <= div_req.divisor;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[DIV_NUM_W-DIV_DIGIT-1:0], qbits_in};
            rem_ff <= rem_in;
            if (step_ff == SW'(STEPS - 1)) begin
               busy_ff <= 1'b0;
            end else begin
               step_ff <= step_ff + SW'(1);
            end
         end
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
